/* hdl/assert_macros.svh */
// shared assertion macros, clocked on clk_i and disabled during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// condition must never be true out of reset
`define ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* hdl/mst_pkg.sv */
package mst_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int MAX_EDGES    = 64;

  localparam int VIDX_W = 5;
  localparam int VCNT_W = 6;
  localparam int WGT_W  = 16;
  localparam int LIDX_W = $clog2(MAX_VERTICES);
  localparam int EIDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ECNT_W = $clog2(MAX_EDGES + 1);
  localparam int RBUF_DEPTH = MAX_VERTICES - 1;
  localparam int RIDX_W = $clog2(MAX_VERTICES);

  typedef struct packed {
    logic [VIDX_W-1:0]       src_vertex;
    logic [VIDX_W-1:0]       dst_vertex;
    logic signed [WGT_W-1:0] edge_weight;
    logic                    last_edge;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]       out_src;
    logic [VIDX_W-1:0]       out_dst;
    logic signed [WGT_W-1:0] out_weight;
    logic                    edge_valid;
    logic                    dropped_any;
    logic                    last_result;
  } out_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]       src;
    logic [VIDX_W-1:0]       dst;
    logic signed [WGT_W-1:0] wgt;
  } edge_t;

  // commands from controller to datapath
  typedef struct packed {
    logic store;
    logic sort_rd_i;
    logic sort_cap_i;
    logic sort_rd_j;
    logic sort_cmp;
    logic sort_wr;
    logic uf_init;
    logic sc_rd_ord;
    logic sc_rd_edge;
    logic sc_chk;
    logic sc_lb;
    logic sc_next;
    logic em_rd;
    logic em_load;
    logic em_null;
    logic out_take;
  } mst_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic sort_more;
    logic j_last;
    logic scan_more;
    logic range_ok;
    logic chosen_zero;
    logic out_last;
  } mst_stat_t;

endpackage

/* hdl/mst_ctrl.sv */
module mst_ctrl import mst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  mst_stat_t stat_i,
  output logic      in_ready_o,
  output mst_cmd_t  cmd_o
);

  typedef enum logic [17:0] {
    S_IDLE       = 18'h00001,
    S_SORT_TEST  = 18'h00002,
    S_SORT_RD_I  = 18'h00004,
    S_SORT_CAP_I = 18'h00008,
    S_SORT_RD_J  = 18'h00010,
    S_SORT_CMP   = 18'h00020,
    S_SORT_WR    = 18'h00040,
    S_UF_INIT    = 18'h00080,
    S_SC_TEST    = 18'h00100,
    S_SC_RD_ORD  = 18'h00200,
    S_SC_RD_EDGE = 18'h00400,
    S_SC_CHK     = 18'h00800,
    S_SC_LB      = 18'h01000,
    S_SC_NEXT    = 18'h02000,
    S_EM_RD      = 18'h04000,
    S_EM_LOAD    = 18'h08000,
    S_EM_NULL    = 18'h10000,
    S_EM_WAIT    = 18'h20000
  } state_e;

  state_e state_q, state_d;
  logic   out_take;

  assign out_take   = out_valid_i && out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:       if (in_valid_i && in_last_i) state_d = S_SORT_TEST;
      S_SORT_TEST:  state_d = stat_i.sort_more ? S_SORT_RD_I : S_UF_INIT;
      S_SORT_RD_I:  state_d = S_SORT_CAP_I;
      S_SORT_CAP_I: state_d = S_SORT_RD_J;
      S_SORT_RD_J:  state_d = S_SORT_CMP;
      S_SORT_CMP:   state_d = stat_i.j_last ? S_SORT_WR : S_SORT_RD_J;
      S_SORT_WR:    state_d = S_SORT_TEST;
      S_UF_INIT:    state_d = S_SC_TEST;
      S_SC_TEST: begin
        if (stat_i.scan_more) state_d = S_SC_RD_ORD;
        else state_d = stat_i.chosen_zero ? S_EM_NULL : S_EM_RD;
      end
      S_SC_RD_ORD:  state_d = S_SC_RD_EDGE;
      S_SC_RD_EDGE: state_d = S_SC_CHK;
      S_SC_CHK:     state_d = stat_i.range_ok ? S_SC_LB : S_SC_NEXT;
      S_SC_LB:      state_d = S_SC_NEXT;
      S_SC_NEXT:    state_d = S_SC_TEST;
      S_EM_RD:      state_d = S_EM_LOAD;
      S_EM_LOAD:    state_d = S_EM_WAIT;
      S_EM_NULL:    state_d = S_EM_WAIT;
      S_EM_WAIT: begin
        if (out_take) state_d = stat_i.out_last ? S_IDLE : S_EM_RD;
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // command decode
  always_comb begin
    cmd_o            = '0;
    cmd_o.store      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.sort_rd_i  = (state_q == S_SORT_RD_I);
    cmd_o.sort_cap_i = (state_q == S_SORT_CAP_I);
    cmd_o.sort_rd_j  = (state_q == S_SORT_RD_J);
    cmd_o.sort_cmp   = (state_q == S_SORT_CMP);
    cmd_o.sort_wr    = (state_q == S_SORT_WR);
    cmd_o.uf_init    = (state_q == S_UF_INIT);
    cmd_o.sc_rd_ord  = (state_q == S_SC_RD_ORD);
    cmd_o.sc_rd_edge = (state_q == S_SC_RD_EDGE);
    cmd_o.sc_chk     = (state_q == S_SC_CHK);
    cmd_o.sc_lb      = (state_q == S_SC_LB);
    cmd_o.sc_next    = (state_q == S_SC_NEXT);
    cmd_o.em_rd      = (state_q == S_EM_RD);
    cmd_o.em_load    = (state_q == S_EM_LOAD);
    cmd_o.em_null    = (state_q == S_EM_NULL);
    cmd_o.out_take   = (state_q == S_EM_WAIT) && out_take;
  end

endmodule

/* hdl/mst_dpath.sv */
module mst_dpath import mst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [VCNT_W-1:0] cfg_wdata_i,
  input  in_item_t          in_item_i,
  input  mst_cmd_t          cmd_i,
  output mst_stat_t         stat_o,
  output logic              out_valid_o,
  output out_item_t         out_item_o
);
  `include "assert_macros.svh"

  logic [VCNT_W-1:0] vcount_q;
  logic [VCNT_W-1:0] n_eff;
  logic [ECNT_W-1:0] cnt_q, i_q, j_q, k_q;
  logic [EIDX_W-1:0] pos_q;
  logic [RIDX_W-1:0] chosen_q, e_q;
  logic              drop_q;
  logic              out_valid_q;
  out_item_t         out_q;

  edge_t             edge_mem [MAX_EDGES];
  edge_t             edge_rd_q;
  logic [EIDX_W-1:0] edge_raddr;
  logic [EIDX_W-1:0] ord_mem [MAX_EDGES];
  logic [EIDX_W-1:0] ord_rd_q;
  edge_t             rbuf_mem [RBUF_DEPTH];
  edge_t             rbuf_rd_q;

  logic [VIDX_W-1:0] label_q [MAX_VERTICES];
  logic [VIDX_W-1:0] la_q;
  logic [VIDX_W-1:0] lab_rd;
  logic [LIDX_W-1:0] lab_addr;

  logic              in_ok;
  logic signed [WGT_W-1:0] wi_q;
  logic              less;

  // effective vertex count
  always_comb begin
    if (vcount_q == '0) n_eff = VCNT_W'(1);
    else if (vcount_q > VCNT_W'(MAX_VERTICES)) n_eff = VCNT_W'(MAX_VERTICES);
    else n_eff = vcount_q;
  end

  assign in_ok = ({1'b0, in_item_i.src_vertex} < n_eff) &&
                 ({1'b0, in_item_i.dst_vertex} < n_eff) &&
                 (cnt_q < ECNT_W'(MAX_EDGES));

  // stable order: earlier edge with equal weight goes first
  assign less = (edge_rd_q.wgt < wi_q) || ((edge_rd_q.wgt == wi_q) && (j_q < i_q));

  assign edge_raddr = cmd_i.sc_rd_edge ? ord_rd_q :
                      (cmd_i.sort_rd_i ? i_q[EIDX_W-1:0] : j_q[EIDX_W-1:0]);

  assign lab_addr = cmd_i.sc_chk ? edge_rd_q.src[LIDX_W-1:0] : edge_rd_q.dst[LIDX_W-1:0];
  assign lab_rd   = label_q[lab_addr];

  // status
  assign stat_o.sort_more   = (i_q < cnt_q);
  assign stat_o.j_last      = ((j_q + ECNT_W'(1)) == cnt_q);
  assign stat_o.scan_more   = (k_q < cnt_q) &&
                              ((VCNT_W'(chosen_q) + VCNT_W'(1)) < n_eff);
  assign stat_o.range_ok    = ({1'b0, edge_rd_q.src} < n_eff) &&
                              ({1'b0, edge_rd_q.dst} < n_eff);
  assign stat_o.chosen_zero = (chosen_q == '0);
  assign stat_o.out_last    = out_q.last_result;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // edge store and its registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store && in_ok) begin
      edge_mem[cnt_q[EIDX_W-1:0]] <= '{src: in_item_i.src_vertex,
                                       dst: in_item_i.dst_vertex,
                                       wgt: in_item_i.edge_weight};
    end
    if (cmd_i.sort_rd_i || cmd_i.sort_rd_j || cmd_i.sc_rd_edge) begin
      edge_rd_q <= edge_mem[edge_raddr];
    end
  end

  // sorted order memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_wr) ord_mem[pos_q] <= i_q[EIDX_W-1:0];
    if (cmd_i.sc_rd_ord) ord_rd_q <= ord_mem[k_q[EIDX_W-1:0]];
  end

  // chosen edge buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_lb && (lab_rd != la_q)) rbuf_mem[chosen_q] <= edge_rd_q;
    if (cmd_i.em_rd) rbuf_rd_q <= rbuf_mem[e_q];
  end

  // sort working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.sort_cap_i) wi_q <= edge_rd_q.wgt;
    if (cmd_i.sc_chk) la_q <= lab_rd;
    if (cmd_i.sort_cap_i) pos_q <= '0;
    else if (cmd_i.sort_cmp && less) pos_q <= pos_q + EIDX_W'(1);
  end

  // component labels, merged by relabeling every entry that holds the old label
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int v = 0; v < MAX_VERTICES; v++) label_q[v] <= VIDX_W'(v);
    end else if (cmd_i.uf_init) begin
      for (int v = 0; v < MAX_VERTICES; v++) label_q[v] <= VIDX_W'(v);
    end else if (cmd_i.sc_lb && (lab_rd != la_q)) begin
      for (int v = 0; v < MAX_VERTICES; v++) begin
        if (label_q[v] == lab_rd) label_q[v] <= la_q;
      end
    end
  end

  // control counters and flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= VCNT_W'(32);
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      chosen_q    <= '0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) vcount_q <= cfg_wdata_i;
      if (cmd_i.store) begin
        i_q <= '0;
        if (in_ok) cnt_q <= cnt_q + ECNT_W'(1);
        else drop_q <= 1'b1;
      end
      if (cmd_i.sort_wr) i_q <= i_q + ECNT_W'(1);
      if (cmd_i.sort_cap_i) j_q <= '0;
      else if (cmd_i.sort_cmp) j_q <= j_q + ECNT_W'(1);
      if (cmd_i.uf_init) begin
        k_q      <= '0;
        chosen_q <= '0;
        e_q      <= '0;
      end
      if (cmd_i.sc_chk && !stat_o.range_ok) drop_q <= 1'b1;
      if (cmd_i.sc_lb && (lab_rd != la_q)) chosen_q <= chosen_q + RIDX_W'(1);
      if (cmd_i.sc_next) k_q <= k_q + ECNT_W'(1);
      if (cmd_i.em_load || cmd_i.em_null) out_valid_q <= 1'b1;
      if (cmd_i.out_take) begin
        out_valid_q <= 1'b0;
        e_q         <= e_q + RIDX_W'(1);
        if (out_q.last_result) begin
          cnt_q    <= '0;
          drop_q   <= 1'b0;
          chosen_q <= '0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.em_load) begin
      out_q <= '{out_src: rbuf_rd_q.src, out_dst: rbuf_rd_q.dst,
                 out_weight: rbuf_rd_q.wgt, edge_valid: 1'b1,
                 dropped_any: drop_q,
                 last_result: ((e_q + RIDX_W'(1)) == chosen_q)};
    end else if (cmd_i.em_null) begin
      out_q <= '{out_src: '0, out_dst: '0, out_weight: '0, edge_valid: 1'b0,
                 dropped_any: drop_q, last_result: 1'b1};
    end
  end

  `ASSERT_NEVER(a_cnt_range, cnt_q > ECNT_W'(MAX_EDGES))
  `ASSERT_CLK(a_chosen_inc, (cmd_i.sc_lb && (lab_rd != la_q)) |=> (chosen_q == $past(chosen_q) + RIDX_W'(1)))
  `ASSERT_NEVER(a_rbuf_over, cmd_i.sc_lb && (lab_rd != la_q) && (VCNT_W'(chosen_q) + VCNT_W'(1) >= n_eff))

endmodule

/* hdl/minimum_spanning_tree_kruskal.sv */
// Kruskal minimum spanning tree. Edges are taken one per cycle while the block is idle and
// stored in order; the edge with last_edge set starts the run, and in_ready_o stays low until
// the last result is taken. Edges are ordered by rank counting, each compare reading a stored
// edge through the single edge memory read port; the union-find scan then walks the sorted
// edges, and emission of each result waits on any output stall. The user writes vertex_count
// through cfg_we_i and cfg_wdata_i only between graphs; the block does not enforce this.
module minimum_spanning_tree_kruskal import mst_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [VCNT_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  mst_cmd_t  cmd;
  mst_stat_t stat;

  // sequencing
  mst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_item_i.last_edge),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd)
  );

  // storage and compute
  mst_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import mst_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [VCNT_W-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_item_i;
  logic              out_valid_o;
  logic              out_ready_i;
  out_item_t         out_item_o;

  minimum_spanning_tree_kruskal dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // clock generation
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // predictor state
  edge_t             graph_edges[MAX_EDGES];
  int                graph_count;
  logic              graph_dropped;
  logic [VCNT_W-1:0] vcount_reg;
  out_item_t         tree_queue[$];

  int error_count;
  int edges_sent;
  int results_seen;
  int graphs_done;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic int find_root(ref logic [4:0] par[MAX_VERTICES], input int v);
    int r;
    int nxt;
    r = v;
    while (par[r] != r) r = par[r];
    while (par[v] != r) begin
      nxt = par[v];
      par[v] = 5'(r);
      v = nxt;
    end
    return r;
  endfunction

  // models one accepted edge, queues the tree on the final one
  task automatic predict_edge(input in_item_t it);
    int n;
    int order[MAX_EDGES];
    logic [4:0] par[MAX_VERTICES];
    logic [4:0] rnk[MAX_VERTICES];
    int j;
    int cur;
    int chosen;
    int x;
    int y;
    out_item_t o;
    out_item_t picks[$];
    edge_t e;
    n = (vcount_reg == 0) ? 1 : (vcount_reg > MAX_VERTICES ? MAX_VERTICES : vcount_reg);
    if (it.src_vertex < n && it.dst_vertex < n && graph_count < MAX_EDGES) begin
      graph_edges[graph_count] = '{it.src_vertex, it.dst_vertex, it.edge_weight};
      graph_count++;
    end else begin
      graph_dropped = 1'b1;
    end
    if (!it.last_edge) return;
    // stable insertion sort on signed weight
    for (int i = 0; i < graph_count; i++) begin
      j = i;
      cur = i;
      while (j > 0 && graph_edges[order[j-1]].wgt > graph_edges[cur].wgt) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = cur;
    end
    for (int i = 0; i < MAX_VERTICES; i++) begin
      par[i] = 5'(i);
      rnk[i] = '0;
    end
    chosen = 0;
    for (int i = 0; i < graph_count && chosen + 1 < n; i++) begin
      e = graph_edges[order[i]];
      // stored edge outside the current vertex count is skipped
      if (e.src >= n || e.dst >= n) begin
        graph_dropped = 1'b1;
        continue;
      end
      x = find_root(par, e.src);
      y = find_root(par, e.dst);
      if (x != y) begin
        o = '0;
        o.out_src = e.src;
        o.out_dst = e.dst;
        o.out_weight = e.wgt;
        o.edge_valid = 1'b1;
        picks.push_back(o);
        chosen++;
        if (rnk[x] < rnk[y]) par[x] = 5'(y);
        else if (rnk[x] > rnk[y]) par[y] = 5'(x);
        else begin
          par[y] = 5'(x);
          rnk[x] = rnk[x] + 5'd1;
        end
      end
    end
    if (chosen == 0) begin
      o = '0;
      picks.push_back(o);
    end
    foreach (picks[k]) begin
      picks[k].dropped_any = graph_dropped;
      picks[k].last_result = (k == picks.size() - 1);
      tree_queue.push_back(picks[k]);
    end
    graph_count = 0;
    graph_dropped = 1'b0;
  endtask

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(5, 30);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // input driver, valid held across back-to-back transactions
  task automatic send_edge(input in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_edge(it);
    edges_sent++;
  endtask

  task automatic write_vcount(input logic [VCNT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (tree_queue.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    vcount_reg = v;
  endtask

  function automatic in_item_t mk(input int s, input int d, input int w, input bit l);
    in_item_t it;
    it.src_vertex  = VIDX_W'(s);
    it.dst_vertex  = VIDX_W'(d);
    it.edge_weight = WGT_W'(w);
    it.last_edge   = l;
    return it;
  endfunction

  // output side: random stall and compare
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (tree_queue.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          exp_item = tree_queue.pop_front();
          if (out_item_o.out_src !== exp_item.out_src)
            report_mismatch($sformatf("out_src %0d exp %0d", out_item_o.out_src,
                                      exp_item.out_src));
          if (out_item_o.out_dst !== exp_item.out_dst)
            report_mismatch($sformatf("out_dst %0d exp %0d", out_item_o.out_dst,
                                      exp_item.out_dst));
          if (out_item_o.out_weight !== exp_item.out_weight)
            report_mismatch($sformatf("out_weight %0d exp %0d", out_item_o.out_weight,
                                      exp_item.out_weight));
          if (out_item_o.edge_valid !== exp_item.edge_valid)
            report_mismatch("edge_valid differs");
          if (out_item_o.dropped_any !== exp_item.dropped_any)
            report_mismatch("dropped_any differs");
          if (out_item_o.last_result !== exp_item.last_result)
            report_mismatch("last_result differs");
          if (exp_item.last_result) graphs_done++;
        end
      end
      out_ready_i <= ($urandom_range(0, 15) == 0) ? 1'b0 :
                     ($urandom_range(0, 3) != 0);
    end
  end

  // directed stimulus table; known results typed where obvious
  typedef struct {
    in_item_t  it;
    bit        has_exp;
    out_item_t exp_item;
  } dir_row_t;

  // random graph of given vertex count, with an occasional out-of-range endpoint
  task automatic random_graph(input int nv, input int ne);
    int s;
    int d;
    for (int k = 0; k < ne; k++) begin
      if ($urandom_range(0, 19) == 0) begin
        s = $urandom_range(0, 31);
        d = $urandom_range(0, 31);
      end else begin
        s = $urandom_range(0, nv - 1);
        d = $urandom_range(0, nv - 1);
      end
      send_edge(mk(s, d, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) - 4
                                                       : $urandom_range(0, 65535),
                   k == ne - 1));
    end
  endtask

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    int sizes[6] = '{32, 1, 2, 0, 63, 5};
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    vcount_reg  = 6'd32;
    graph_count = 0;
    graph_dropped = 1'b0;
    error_count = 0;
    edges_sent = 0;
    results_seen = 0;
    graphs_done = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // self-loop alone: nothing chosen
    r.it = mk(0, 0, 5, 1); r.has_exp = 1; r.exp_item = '0; r.exp_item.last_result = 1;
    rows.push_back(r);
    // out-of-range impossible at 32; extremes of weight and endpoints
    r.has_exp = 0;
    r.it = mk(31, 0, 32767, 0); rows.push_back(r);
    r.it = mk(0, 31, -32768, 0); rows.push_back(r);
    r.it = mk(31, 31, 0, 0); rows.push_back(r);
    r.it = mk(5, 10, -32768, 0); rows.push_back(r);
    r.it = mk(10, 21, 21845, 0); rows.push_back(r);
    r.it = mk(21, 5, -21846, 1); rows.push_back(r);
    foreach (rows[k]) begin
      send_edge(rows[k].it);
      if (rows[k].has_exp && tree_queue.size() > 0 &&
          tree_queue[tree_queue.size()-1] !== rows[k].exp_item)
        report_mismatch("directed row prediction differs from table");
    end

    // small count: a range drop on the final edge
    write_vcount(6'd3);
    send_edge(mk(0, 1, 2, 0));
    send_edge(mk(1, 2, 2, 0));
    send_edge(mk(0, 2, 1, 0));
    send_edge(mk(3, 0, 1, 1));
    // count 0 acts as one vertex: nothing chosen
    write_vcount(6'd0);
    send_edge(mk(0, 0, 1, 1));
    // count above the maximum acts as the maximum
    write_vcount(6'd63);
    send_edge(mk(30, 31, -1, 1));
    // store overflow: 66 items sent at count 32, two past the store depth
    write_vcount(6'd32);
    for (int k = 0; k < 66; k++)
      send_edge(mk($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 65535),
                   k == 65));

    // random graphs, mostly small
    while (edges_sent < 400) begin
      write_vcount(VCNT_W'(sizes[$urandom_range(0, 5)] == 5 ? $urandom_range(1, 32)
                                                             : sizes[$urandom_range(0, 5)]));
      random_graph((vcount_reg == 0) ? 1 : (vcount_reg > 32 ? 32 : vcount_reg),
                   $urandom_range(1, 12));
    end

    in_valid_i <= 1'b0;
    while (tree_queue.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("covered %0d edges in %0d graphs, %0d results checked", edges_sent, graphs_done,
             results_seen);
    $display("vertex counts from zero to the maximum and beyond, with drops and overflow");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

endmodule
